### hdl/bia_pkg.sv
// Shared types, constants and helper functions of the bitmap id allocator.
// No dependencies; every other file of the block uses this package.
`default_nettype none
package bia_pkg;

	localparam int MAX_IDS = 1024;
	localparam int ID_W    = $clog2(MAX_IDS);
	localparam int LIM_W   = ID_W + 1;
	localparam int GEN_W   = 32;
	localparam int COL_W   = (ID_W > 5) ? 5 : ID_W - 1;
	localparam int ROW_W   = ID_W - COL_W;
	localparam int WORD    = 1 << COL_W;
	localparam int ROWS    = MAX_IDS >> COL_W;

	typedef enum logic [2:0] {
		CMD_ALLOC,
		CMD_PEEK,
		CMD_REGISTER,
		CMD_UNREGISTER,
		CMD_MOVE_BEGIN,
		CMD_MOVE_END,
		CMD_HOLD,
		CMD_SET_ACTIVE
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_FREE,
		ST_CHECK_FAIL
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ID_W-1:0]   doc_id;
		logic [ID_W-1:0]   dest_id;
		logic [LIM_W-1:0]  id_limit;
		logic              make_active;
		logic [GEN_W-1:0]  generation;
		logic              build_list;
	} req_t;

	typedef struct packed {
		logic [LIM_W-1:0]  id_out;
		logic [GEN_W-1:0]  gen_out;
		logic              hold_valid;
		logic [LIM_W-1:0]  active_total;
		status_t           status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_BLD_RD,
		S_BLD_WR,
		S_SRCH_RD,
		S_SRCH_WR,
		S_RD_A,
		S_RD_B,
		S_EXEC,
		S_WR_A,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		RD_ROW_A,
		RD_ROW_B,
		RD_SRCH,
		RD_BLD
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_ROW_B,
		WR_ROW_A,
		WR_SRCH,
		WR_BLD
	} wr_sel_t;

	typedef struct packed {
		logic    latch_req;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cap_a;
		logic    exec;
		logic    srch_done;
		logic    bld_clr;
		logic    bld_step;
		logic    set_built;
		logic    build_fail;
		logic    load_out;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic build;
		logic built;
		logic bld_last;
		logic out_busy;
	} dp_stat_t;

	function automatic logic [COL_W-1:0] low_col(input logic [WORD-1:0] v);
		logic [COL_W-1:0] r;
		r = '0;
		for (int i = WORD - 1; i >= 0; i--) begin
			if (v[i]) r = COL_W'(i);
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] low_row(input logic [ROWS-1:0] v);
		logic [ROW_W-1:0] r;
		r = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (v[i]) r = ROW_W'(i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/bia_req_if.sv
// Command channel of the bitmap id allocator: valid, ready and request payload.
// Depends on bia_pkg.
`default_nettype none
interface bia_req_if;
	logic          valid;
	logic          ready;
	bia_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/bia_rsp_if.sv
// Result channel of the bitmap id allocator: valid, ready and result payload.
// Depends on bia_pkg.
`default_nettype none
interface bia_rsp_if;
	logic          valid;
	logic          ready;
	bia_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/bia_ctrl.sv
// Controller of the bitmap id allocator: sequences reads, writes, build sweep.
// Depends on bia_pkg; drives bia_datapath through dp_cmd_t.
`default_nettype none
module bia_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire bia_pkg::dp_stat_t stat,
	output bia_pkg::dp_cmd_t       cmd
);

	bia_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bia_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			bia_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					state_nxt     = bia_pkg::S_DISPATCH;
				end
			end
			bia_pkg::S_DISPATCH: begin
				if (stat.cmd == bia_pkg::CMD_ALLOC && stat.build) begin
					if (stat.built) begin
						cmd.build_fail = 1'b1;
						state_nxt      = bia_pkg::S_FIN;
					end else begin
						cmd.bld_clr = 1'b1;
						state_nxt   = bia_pkg::S_BLD_RD;
					end
				end else if (stat.cmd == bia_pkg::CMD_ALLOC ||
				             stat.cmd == bia_pkg::CMD_PEEK) begin
					state_nxt = bia_pkg::S_SRCH_RD;
				end else begin
					state_nxt = bia_pkg::S_RD_A;
				end
			end
			bia_pkg::S_BLD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bia_pkg::RD_BLD;
				state_nxt  = bia_pkg::S_BLD_WR;
			end
			bia_pkg::S_BLD_WR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = bia_pkg::WR_BLD;
				cmd.bld_step = 1'b1;
				if (stat.bld_last) begin
					cmd.set_built = 1'b1;
					state_nxt     = bia_pkg::S_SRCH_RD;
				end else begin
					state_nxt = bia_pkg::S_BLD_RD;
				end
			end
			bia_pkg::S_SRCH_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bia_pkg::RD_SRCH;
				state_nxt  = bia_pkg::S_SRCH_WR;
			end
			bia_pkg::S_SRCH_WR: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = bia_pkg::WR_SRCH;
				cmd.srch_done = 1'b1;
				state_nxt     = bia_pkg::S_FIN;
			end
			bia_pkg::S_RD_A: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bia_pkg::RD_ROW_A;
				state_nxt  = bia_pkg::S_RD_B;
			end
			bia_pkg::S_RD_B: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bia_pkg::RD_ROW_B;
				cmd.cap_a  = 1'b1;
				state_nxt  = bia_pkg::S_EXEC;
			end
			bia_pkg::S_EXEC: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = bia_pkg::WR_ROW_B;
				cmd.exec   = 1'b1;
				state_nxt  = bia_pkg::S_WR_A;
			end
			bia_pkg::S_WR_A: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = bia_pkg::WR_ROW_A;
				state_nxt  = bia_pkg::S_FIN;
			end
			bia_pkg::S_FIN: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_nxt    = bia_pkg::S_IDLE;
				end
			end
			default: state_nxt = bia_pkg::S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

### hdl/bia_datapath.sv
// Datapath of the bitmap id allocator: four row-organized bitmaps, free summary,
// active count, row read-modify-write, build sweep and output register. Uses bia_pkg.
`default_nettype none
module bia_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bia_pkg::req_t    req_data,
	input  wire bia_pkg::dp_cmd_t cmd,
	output bia_pkg::dp_stat_t     stat,
	output logic                  rsp_valid,
	output bia_pkg::rsp_t         rsp_data,
	input  wire logic             rsp_ready
);

	localparam int WORD  = bia_pkg::WORD;
	localparam int ROWS  = bia_pkg::ROWS;
	localparam int ROW_W = bia_pkg::ROW_W;
	localparam int COL_W = bia_pkg::COL_W;
	localparam int ID_W  = bia_pkg::ID_W;
	localparam int LIM_W = bia_pkg::LIM_W;

	logic [WORD-1:0] free_mem [ROWS];
	logic [WORD-1:0] used_mem [ROWS];
	logic [WORD-1:0] pend_mem [ROWS];
	logic [WORD-1:0] act_mem  [ROWS];
	logic [ROWS-1:0] free_vld_q, used_vld_q, pend_vld_q, act_vld_q;
	logic [ROWS-1:0] sum_q;

	bia_pkg::req_t   req_q;
	logic            built_q;
	logic [LIM_W-1:0] cnt_q;
	logic [ROW_W-1:0] bld_row_q;
	logic [ROW_W-1:0] srch_row_q;
	logic            sum_any_q;
	logic [WORD-1:0] f_rd_q, u_rd_q, p_rd_q, a_rd_q;
	logic [WORD-1:0] fa_q, ua_q, pa_q, aa_q;
	logic [WORD-1:0] naf_q, nau_q, nap_q, naa_q;
	logic            err_q;
	bia_pkg::rsp_t   res_q;
	bia_pkg::rsp_t   out_q;
	logic            out_vld_q;

	logic [ROW_W-1:0] ra, rb, rd_addr, wr_addr;
	logic [COL_W-1:0] ac, bc, scol;
	logic             same_row;
	logic             fa, fb, pa, pb, act_a, act_b;
	logic             err, hold_ok;
	logic [LIM_W-1:0] cnt_nxt;
	logic [WORD-1:0]  nbf, nbu, nbp, nba, naf, nau, nap, naa;
	logic [WORD-1:0]  bld_mask, srch_new;
	logic [ID_W-1:0]  sid;
	logic             found;
	logic             we_all, we_free;
	logic [WORD-1:0]  wd_f, wd_u, wd_p, wd_a;

	assign ra       = req_q.doc_id[ID_W-1:COL_W];
	assign ac       = req_q.doc_id[COL_W-1:0];
	assign rb       = req_q.dest_id[ID_W-1:COL_W];
	assign bc       = req_q.dest_id[COL_W-1:0];
	assign same_row = (ra == rb);
	assign fa       = fa_q[ac];
	assign pa       = pa_q[ac];
	assign act_a    = aa_q[ac];
	assign fb       = f_rd_q[bc];
	assign pb       = p_rd_q[bc];
	assign act_b    = a_rd_q[bc];

	always_comb begin
		unique case (cmd.rd_sel)
			bia_pkg::RD_ROW_A: rd_addr = ra;
			bia_pkg::RD_ROW_B: rd_addr = rb;
			bia_pkg::RD_SRCH:  rd_addr = bia_pkg::low_row(sum_q);
			bia_pkg::RD_BLD:   rd_addr = bld_row_q;
			default:           rd_addr = '0;
		endcase
	end

	// row operation of the single-id commands
	always_comb begin
		err     = 1'b0;
		hold_ok = 1'b0;
		cnt_nxt = cnt_q;
		case (req_q.cmd)
			bia_pkg::CMD_UNREGISTER: err = pa;
			bia_pkg::CMD_MOVE_BEGIN: err = pa | pb | (built_q & (fa | !fb));
			bia_pkg::CMD_HOLD: begin
				err     = !built_q || (req_q.doc_id == '0) ||
				          ({1'b0, req_q.doc_id} >= req_q.id_limit) || !pa;
				hold_ok = !err;
			end
			default: err = 1'b0;
		endcase

		nbf = f_rd_q;
		nbu = u_rd_q;
		nbp = p_rd_q;
		nba = a_rd_q;
		if (!err) begin
			case (req_q.cmd)
				bia_pkg::CMD_MOVE_BEGIN: begin
					if (built_q) nbf[bc] = 1'b0;
				end
				bia_pkg::CMD_MOVE_END: begin
					nbu[bc] = 1'b1;
					if (act_a) nba[bc] = 1'b1;
				end
				default: ;
			endcase
		end

		naf = same_row ? nbf : fa_q;
		nau = same_row ? nbu : ua_q;
		nap = same_row ? nbp : pa_q;
		naa = same_row ? nba : aa_q;
		if (!err) begin
			case (req_q.cmd)
				bia_pkg::CMD_REGISTER: nau[ac] = 1'b1;
				bia_pkg::CMD_UNREGISTER: begin
					if (built_q) nap[ac] = 1'b1;
					nau[ac] = 1'b0;
					naa[ac] = 1'b0;
					if (act_a) cnt_nxt = cnt_q - LIM_W'(1);
				end
				bia_pkg::CMD_MOVE_END: begin
					if (built_q) nap[ac] = 1'b1;
					nau[ac] = 1'b0;
					if (act_a) begin
						naa[ac] = 1'b0;
						if (act_b) cnt_nxt = cnt_q - LIM_W'(1);
					end
				end
				bia_pkg::CMD_HOLD: nap[ac] = 1'b0;
				bia_pkg::CMD_SET_ACTIVE: begin
					naa[ac] = req_q.make_active;
					if (req_q.make_active && !act_a) cnt_nxt = cnt_q + LIM_W'(1);
					if (!req_q.make_active && act_a) cnt_nxt = cnt_q - LIM_W'(1);
				end
				default: ;
			endcase
		end
	end

	assign scol     = bia_pkg::low_col(f_rd_q);
	assign sid      = {srch_row_q, scol};
	assign found    = sum_any_q && ({1'b0, sid} < req_q.id_limit);
	assign srch_new = f_rd_q & ~(WORD'(1) << scol);

	always_comb begin
		for (int c = 0; c < WORD; c++) begin
			bld_mask[c] = ({bld_row_q, COL_W'(c)} != '0) &&
			              ({1'b0, bld_row_q, COL_W'(c)} < req_q.id_limit);
		end
	end

	always_comb begin
		we_all  = 1'b0;
		we_free = 1'b0;
		wr_addr = '0;
		wd_f    = nbf;
		wd_u    = nbu;
		wd_p    = nbp;
		wd_a    = nba;
		unique case (cmd.wr_sel)
			bia_pkg::WR_ROW_B: begin
				we_all  = cmd.wr_en && !err;
				wr_addr = rb;
			end
			bia_pkg::WR_ROW_A: begin
				we_all  = cmd.wr_en && !err_q;
				wr_addr = ra;
				wd_f    = naf_q;
				wd_u    = nau_q;
				wd_p    = nap_q;
				wd_a    = naa_q;
			end
			bia_pkg::WR_SRCH: begin
				we_free = cmd.wr_en && found && (req_q.cmd == bia_pkg::CMD_ALLOC);
				wr_addr = srch_row_q;
				wd_f    = srch_new;
			end
			bia_pkg::WR_BLD: begin
				we_free = cmd.wr_en;
				wr_addr = bld_row_q;
				wd_f    = f_rd_q | (~u_rd_q & bld_mask);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_all || we_free) free_mem[wr_addr] <= wd_f;
		if (we_all) begin
			used_mem[wr_addr] <= wd_u;
			pend_mem[wr_addr] <= wd_p;
			act_mem[wr_addr]  <= wd_a;
		end
		if (cmd.rd_en) begin
			f_rd_q <= free_vld_q[rd_addr] ? free_mem[rd_addr] : '0;
			u_rd_q <= used_vld_q[rd_addr] ? used_mem[rd_addr] : '0;
			p_rd_q <= pend_vld_q[rd_addr] ? pend_mem[rd_addr] : '0;
			a_rd_q <= act_vld_q[rd_addr] ? act_mem[rd_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_vld_q <= '0;
			used_vld_q <= '0;
			pend_vld_q <= '0;
			act_vld_q  <= '0;
			sum_q      <= '0;
			built_q    <= 1'b0;
			cnt_q      <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (we_all || we_free) begin
				free_vld_q[wr_addr] <= 1'b1;
				sum_q[wr_addr]      <= |wd_f;
			end
			if (we_all) begin
				used_vld_q[wr_addr] <= 1'b1;
				pend_vld_q[wr_addr] <= 1'b1;
				act_vld_q[wr_addr]  <= 1'b1;
			end
			if (cmd.set_built) built_q <= 1'b1;
			if (cmd.exec) cnt_q <= cnt_nxt;
			if (cmd.load_out) out_vld_q <= 1'b1;
			else if (rsp_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) req_q <= req_data;
		if (cmd.bld_clr) bld_row_q <= '0;
		else if (cmd.bld_step) bld_row_q <= bld_row_q + ROW_W'(1);
		if (cmd.rd_en && cmd.rd_sel == bia_pkg::RD_SRCH) begin
			srch_row_q <= bia_pkg::low_row(sum_q);
			sum_any_q  <= |sum_q;
		end
		if (cmd.cap_a) begin
			fa_q <= f_rd_q;
			ua_q <= u_rd_q;
			pa_q <= p_rd_q;
			aa_q <= a_rd_q;
		end
		if (cmd.exec) begin
			naf_q <= naf;
			nau_q <= nau;
			nap_q <= nap;
			naa_q <= naa;
			err_q <= err;
			res_q.id_out       <= hold_ok ? {1'b0, req_q.doc_id} : '0;
			res_q.gen_out      <= hold_ok ? req_q.generation : '0;
			res_q.hold_valid   <= hold_ok;
			res_q.active_total <= cnt_nxt;
			res_q.status       <= err ? bia_pkg::ST_CHECK_FAIL : bia_pkg::ST_OK;
		end else if (cmd.srch_done) begin
			res_q.id_out       <= found ? {1'b0, sid} : req_q.id_limit;
			res_q.gen_out      <= '0;
			res_q.hold_valid   <= 1'b0;
			res_q.active_total <= cnt_q;
			res_q.status       <= found ? bia_pkg::ST_OK : bia_pkg::ST_NO_FREE;
		end else if (cmd.build_fail) begin
			res_q.id_out       <= '0;
			res_q.gen_out      <= '0;
			res_q.hold_valid   <= 1'b0;
			res_q.active_total <= cnt_q;
			res_q.status       <= bia_pkg::ST_CHECK_FAIL;
		end
		if (cmd.load_out) out_q <= res_q;
	end

	assign stat.cmd      = req_q.cmd;
	assign stat.build    = req_q.build_list;
	assign stat.built    = built_q;
	assign stat.bld_last = (bld_row_q == ROW_W'(ROWS - 1));
	assign stat.out_busy = out_vld_q && !rsp_ready;
	assign rsp_valid     = out_vld_q;
	assign rsp_data      = out_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LIM_W'(bia_pkg::MAX_IDS))
		else $error("active count above id space");
	a_hold_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.hold_valid |-> out_q.status == bia_pkg::ST_OK)
		else $error("held id with failing status");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(cmd.load_out))
		else $error("result appeared without load");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_vld_q && !rsp_ready))
		else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

### hdl/bitmap_id_allocator.sv
// Top level of the bitmap id allocator: controller plus datapath.
// Depends on bia_pkg, bia_req_if, bia_rsp_if, bia_ctrl, bia_datapath.
//
// Usage: one command transaction enters on req, one result transaction
// leaves on rsp for every command, in order. Commands are taken one at a
// time; req.ready is high only while the controller waits for a command.
// Steps from acceptance to rsp.valid (receiver ready):
//   register, unregister, move begin/end, hold, set active: read row A,
//     read row B, write row B, write row A (two row reads, two row writes
//     through one bitmap port); alloc, peek: summary priority pick, one row read, one row write (alloc only);
//   alloc with build: one row read and write per row, ROWS = MAX_IDS/32 = 32,
//     then the pick; a check failure status if the list is already built.
// The next command is accepted in the cycle after the result is loaded.
// The result sits in an output register; a stalled receiver holds it there,
// and the controller stops before loading the next result until it drains.
// Reset clears all four bitmaps (per-row valid bits), the free summary, the
// active count and the built flag at once; no clearing pass is needed.
`default_nettype none
module bitmap_id_allocator (
	input wire logic   clk,
	input wire logic   arst_n,
	bia_req_if.sink    req,
	bia_rsp_if.source  rsp
);

	bia_pkg::dp_cmd_t  cmd;
	bia_pkg::dp_stat_t stat;

	bia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bia_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data),
		.rsp_ready (rsp.ready)
	);

endmodule
`default_nettype wire

### dv/bitmap_id_allocator_tb.sv
// Self-checking testbench for bitmap_id_allocator: directed table plus random commands,
// every result compared with its checked table row or a predictor of the four id bitmaps.
// Depends on bia_pkg, bia_req_if, bia_rsp_if and the bitmap_id_allocator RTL.
`default_nettype none
module bitmap_id_allocator_tb;

	localparam int MAX_IDS        = bia_pkg::MAX_IDS;
	localparam int ID_W           = bia_pkg::ID_W;
	localparam int LIM_W          = bia_pkg::LIM_W;
	localparam int N_RAND_UNBUILT = 200;
	localparam int N_RAND_BUILT   = 400;
	localparam int SPLIT          = 15;
	localparam int N_ROWS         = 25;

	typedef struct {
		bia_pkg::cmd_t    cmd;
		int               a;
		int               b;
		int               lim;
		bit               mk;
		logic [31:0]      g;
		bit               bld;
		bit               chk;
		int               e_id;
		int               e_act;
		bia_pkg::status_t e_st;
	} row_t;

	row_t dir_tab [N_ROWS] = '{
		'{bia_pkg::CMD_PEEK, 0, 0, 1024, 0, 32'h0, 0, 1, 1024, 0, bia_pkg::ST_NO_FREE},
		'{bia_pkg::CMD_ALLOC, 0, 0, 0, 0, 32'h0, 0, 1, 0, 0, bia_pkg::ST_NO_FREE},
		'{bia_pkg::CMD_ALLOC, 1023, 1023, 2047, 1, 32'hffffffff, 0, 1, 2047, 0,
			bia_pkg::ST_NO_FREE},
		'{bia_pkg::CMD_HOLD, 5, 0, 1024, 0, 32'h1234, 0, 1, 0, 0, bia_pkg::ST_CHECK_FAIL},
		'{bia_pkg::CMD_REGISTER, 1023, 0, 1024, 0, 32'h0, 0, 1, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_SET_ACTIVE, 1023, 0, 1024, 1, 32'h0, 0, 1, 0, 1, bia_pkg::ST_OK},
		'{bia_pkg::CMD_SET_ACTIVE, 0, 0, 1024, 1, 32'h0, 0, 1, 0, 2, bia_pkg::ST_OK},
		'{bia_pkg::CMD_SET_ACTIVE, 0, 0, 1024, 1, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_MOVE_BEGIN, 1023, 0, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_MOVE_END, 1023, 0, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_MOVE_END, 5, 5, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_UNREGISTER, 0, 0, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_SET_ACTIVE, 0, 0, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_REGISTER, 0, 0, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_REGISTER, 7, 0, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		// built regime
		'{bia_pkg::CMD_ALLOC, 0, 0, 1024, 0, 32'h0, 1, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_ALLOC, 0, 0, 1024, 0, 32'h0, 1, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_PEEK, 0, 0, 1, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_UNREGISTER, 3, 0, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_HOLD, 3, 0, 3, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_HOLD, 3, 0, 1024, 0, 32'hffffffff, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_HOLD, 0, 0, 1024, 0, 32'h5, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_MOVE_BEGIN, 2, 1023, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_MOVE_END, 2, 1023, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK},
		'{bia_pkg::CMD_UNREGISTER, 2, 0, 1024, 0, 32'h0, 0, 0, 0, 0, bia_pkg::ST_OK}
	};

	logic clk;
	logic arst_n;

	bia_req_if req_ch ();
	bia_rsp_if rsp_ch ();

	bitmap_id_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bit            free_m    [MAX_IDS];
	bit            used_m    [MAX_IDS];
	bit            pend_m    [MAX_IDS];
	bit            act_m     [MAX_IDS];
	int            act_cnt;
	bit            is_built;
	bia_pkg::rsp_t rsp_q [$];
	int            n_fail;
	bit            send_quiet;
	bit            recv_quiet;
	int            last_a;
	int            last_b;
	bia_pkg::cmd_t last_cmd;

	function automatic void set_act(int id, bit v);
		if (act_m[id] && !v) begin
			act_m[id] = 0;
			act_cnt--;
		end else if (!act_m[id] && v) begin
			act_m[id] = 1;
			act_cnt++;
		end
	endfunction

	function automatic bia_pkg::rsp_t alloc_predict(bia_pkg::req_t r);
		bia_pkg::rsp_t o;
		int   n;
		int   i;
		int   a;
		int   b;
		bit   go;
		o = '0;
		o.status = bia_pkg::ST_OK;
		a = r.doc_id;
		b = r.dest_id;
		n = (r.id_limit < MAX_IDS) ? int'(r.id_limit) : MAX_IDS;
		case (r.cmd)
			bia_pkg::CMD_ALLOC, bia_pkg::CMD_PEEK: begin
				go = 1;
				if (r.cmd == bia_pkg::CMD_ALLOC && r.build_list) begin
					if (is_built) begin
						o.status = bia_pkg::ST_CHECK_FAIL;
						go = 0;
					end else begin
						for (i = 1; i < n; i++)
							if (!used_m[i]) free_m[i] = 1;
						is_built = 1;
					end
				end
				if (go) begin
					o.id_out = r.id_limit;
					o.status = bia_pkg::ST_NO_FREE;
					for (i = 0; i < n; i++) begin
						if (free_m[i]) begin
							o.id_out = LIM_W'(i);
							o.status = bia_pkg::ST_OK;
							if (r.cmd == bia_pkg::CMD_ALLOC) free_m[i] = 0;
							break;
						end
					end
				end
			end
			bia_pkg::CMD_REGISTER: used_m[a] = 1;
			bia_pkg::CMD_UNREGISTER: begin
				if (pend_m[a]) o.status = bia_pkg::ST_CHECK_FAIL;
				else begin
					if (is_built) pend_m[a] = 1;
					used_m[a] = 0;
					set_act(a, 0);
				end
			end
			bia_pkg::CMD_MOVE_BEGIN: begin
				if (pend_m[a] || pend_m[b] || (is_built && (free_m[a] || !free_m[b])))
					o.status = bia_pkg::ST_CHECK_FAIL;
				else if (is_built)
					free_m[b] = 0;
			end
			bia_pkg::CMD_MOVE_END: begin
				if (is_built) pend_m[a] = 1;
				used_m[b] = 1;
				used_m[a] = 0;
				if (act_m[a]) begin
					set_act(b, 1);
					set_act(a, 0);
				end
			end
			bia_pkg::CMD_HOLD: begin
				if (!is_built || a == 0 || a >= r.id_limit || !pend_m[a])
					o.status = bia_pkg::ST_CHECK_FAIL;
				else begin
					pend_m[a] = 0;
					o.id_out = LIM_W'(a);
					o.gen_out = r.generation;
					o.hold_valid = 1;
				end
			end
			default: set_act(a, r.make_active);
		endcase
		o.active_total = LIM_W'(act_cnt);
		return o;
	endfunction

	// random id that is free (sel=0) or pending (sel=1), or -1
	function automatic int scan_id(bit sel);
		int s;
		int k;
		int id;
		s = (($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63));
		for (k = 0; k < 64; k++) begin
			id = (s + k) % MAX_IDS;
			if (sel ? pend_m[id] : free_m[id]) return id;
		end
		return -1;
	endfunction

	function automatic int pick_id();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
	endfunction

	function automatic bia_pkg::req_t random_req(bit built_ph);
		bia_pkg::req_t r;
		int   v;
		int   k;
		r.cmd = bia_pkg::cmd_t'($urandom_range(0, 7));
		r.doc_id = ID_W'(pick_id());
		r.dest_id = ID_W'(pick_id());
		k = $urandom_range(0, 9);
		r.id_limit = (k == 0) ? LIM_W'($urandom_range(0, 2047)) :
			(k == 1) ? LIM_W'($urandom_range(0, 40)) : LIM_W'(1024);
		r.make_active = 1'($urandom_range(0, 1));
		r.generation = $urandom;
		r.build_list = built_ph ? ($urandom_range(0, 15) == 0) : 1'b0;
		if (last_cmd == bia_pkg::CMD_MOVE_BEGIN && $urandom_range(0, 9) < 6) begin
			r.cmd = bia_pkg::CMD_MOVE_END;
			r.doc_id = ID_W'(last_a);
			r.dest_id = ID_W'(last_b);
		end else if (built_ph && r.cmd == bia_pkg::CMD_MOVE_BEGIN &&
		             $urandom_range(0, 9) < 7) begin
			v = scan_id(0);
			if (v >= 0) r.dest_id = ID_W'(v);
			for (k = 0; k < 8 && free_m[r.doc_id]; k++) r.doc_id = ID_W'(pick_id());
		end else if (built_ph && r.cmd == bia_pkg::CMD_HOLD && $urandom_range(0, 9) < 7) begin
			v = scan_id(1);
			if (v >= 0) r.doc_id = ID_W'(v);
		end
		last_cmd = r.cmd;
		last_a = r.doc_id;
		last_b = r.dest_id;
		return r;
	endfunction

	task automatic send_cmd(bia_pkg::req_t r, bit typed, bia_pkg::rsp_t e);
		int            gap;
		bia_pkg::rsp_t p;
		if ($urandom_range(0, 19) == 0) send_quiet = !send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		p = alloc_predict(r);
		rsp_q.insert(rsp_q.size(), typed ? e : p);
	endtask

	task automatic send_row(int i);
		bia_pkg::req_t r;
		bia_pkg::rsp_t e;
		r.cmd = dir_tab[i].cmd;
		r.doc_id = ID_W'(dir_tab[i].a);
		r.dest_id = ID_W'(dir_tab[i].b);
		r.id_limit = LIM_W'(dir_tab[i].lim);
		r.make_active = dir_tab[i].mk;
		r.generation = dir_tab[i].g;
		r.build_list = dir_tab[i].bld;
		e = '0;
		e.id_out = LIM_W'(dir_tab[i].e_id);
		e.active_total = LIM_W'(dir_tab[i].e_act);
		e.status = dir_tab[i].e_st;
		send_cmd(r, dir_tab[i].chk, e);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (rsp_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("bitmap_id_allocator_tb failed");
		$finish;
	end

	initial begin
		bia_pkg::rsp_t e;
		int            gap;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 19) == 0) recv_quiet = !recv_quiet;
			gap = recv_quiet ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			if (rsp_q.size() == 0) begin
				$error("result transaction with nothing expected");
				n_fail++;
			end else begin
				e = rsp_q.pop_front();
				if (rsp_ch.data.id_out !== e.id_out) begin
					$error("id_out exp %0d got %0d", e.id_out, rsp_ch.data.id_out);
					n_fail++;
				end
				if (rsp_ch.data.gen_out !== e.gen_out) begin
					$error("gen_out exp %h got %h", e.gen_out, rsp_ch.data.gen_out);
					n_fail++;
				end
				if (rsp_ch.data.hold_valid !== e.hold_valid) begin
					$error("hold_valid exp %0d got %0d", e.hold_valid, rsp_ch.data.hold_valid);
					n_fail++;
				end
				if (rsp_ch.data.active_total !== e.active_total) begin
					$error("active_total exp %0d got %0d", e.active_total,
						rsp_ch.data.active_total);
					n_fail++;
				end
				if (rsp_ch.data.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp_ch.data.status);
					n_fail++;
				end
			end
		end
	end

	initial begin
		int i;
		n_fail = 0;
		act_cnt = 0;
		is_built = 0;
		send_quiet = 0;
		recv_quiet = 0;
		last_cmd = bia_pkg::CMD_ALLOC;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < SPLIT; i++) send_row(i);
		for (i = 0; i < N_RAND_UNBUILT; i++) send_cmd(random_req(0), 0, '0);
		drain();
		for (i = SPLIT; i < N_ROWS; i++) send_row(i);
		for (i = 0; i < N_RAND_BUILT; i++) send_cmd(random_req(1), 0, '0);
		drain();
		repeat (20) @(posedge clk);
		if (n_fail == 0)
			$display("bitmap_id_allocator_tb passed");
		else
			$display("bitmap_id_allocator_tb failed");
		$finish;
	end

endmodule
`default_nettype wire
